// File: src/tmgr_pkg.sv
// Package: shared constants, types and command/status structs for gradient recovery
package tmgr_pkg;

  localparam int MaxElements = 64;
  localparam int CountW = 7;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_BAD_JAC  = 2'd2,
    STATUS_SAT      = 2'd3
  } status_t;

  // Element datapath operations, one per step
  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_EDGE    = 4'd1,   // edge vectors and field differences
    OP_CROSS   = 4'd2,   // first term of one cross component
    OP_CRSUB   = 4'd3,   // form a cross component
    OP_ACC     = 4'd4,   // one weighted numerator product
    OP_JAC     = 4'd5,   // one Jacobian product
    OP_JACFIN  = 4'd6,   // add Jacobian into sum
    OP_DIVINIT = 4'd7,   // set up a division
    OP_DIVSTEP = 4'd8,   // one quotient bit
    OP_DIVFIN  = 4'd9,   // sign and saturate one component
    OP_CLEAR   = 4'd10   // clear set state
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] idx;   // step index within the operation
    logic [1:0] comp;  // gradient component for division
  } dp_cmd_t;

  typedef struct packed {
    logic jac_nonpos;  // element Jacobian at or below zero
    logic empty;       // no elements or zero Jacobian sum
  } dp_stat_t;

endpackage

// File: src/tmgr_if.sv
// Interfaces: valid/ready channels for vertices and gradient results
interface tmgr_vertex_if (input logic clk);
  logic               valid;
  logic               ready;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;
  logic signed [15:0] coord_z;
  logic signed [15:0] field_value;
  logic               last_in_set;
  modport source (output valid, coord_x, coord_y, coord_z, field_value, last_in_set,
                  input ready);
  modport sink (input valid, coord_x, coord_y, coord_z, field_value, last_in_set,
                output ready);
endinterface

interface tmgr_grad_if (input logic clk);
  logic               valid;
  logic               ready;
  logic signed [31:0] grad_x;
  logic signed [31:0] grad_y;
  logic signed [31:0] grad_z;
  logic [1:0]         status;
  modport source (output valid, grad_x, grad_y, grad_z, status, input ready);
  modport sink (input valid, grad_x, grad_y, grad_z, status, output ready);
endinterface

// File: src/tmgr_datapath.sv
// Datapath: vertex store, shared multiplier pair, accumulators and restoring divider
module tmgr_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic               vtx_we,
  input  logic [1:0]         vtx_pos,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic signed [15:0] coord_z,
  input  logic signed [15:0] field_value,
  input  tmgr_pkg::dp_cmd_t  cmd,
  output tmgr_pkg::dp_stat_t stat,
  output logic signed [31:0] grad [3],
  output logic               sat
);

  // Vertex store: four vertices of x, y, z, u
  logic signed [15:0] vs [4][4];
  // Edge vectors e[0..2][xyz] and field differences du[0..2]
  logic signed [16:0] e [3][3];
  logic signed [16:0] du [3];
  // Cross products cr[i][k]
  logic signed [34:0] cr [3][3];
  logic signed [33:0] prod_a;
  logic signed [63:0] num_sum [3];
  logic signed [63:0] jac_sum;
  logic signed [63:0] jac_acc;
  // Divider
  logic [63:0] div_a;
  logic [63:0] div_d;
  logic [64:0] div_r;
  logic [47:0] div_q;
  logic        div_big;  // quotient grew past the 48-bit register
  logic        div_neg;

  // Operand selection for cross products: cross(p,q) with pairs (1,2),(2,0),(0,1)
  logic [1:0] cp, cq, ck, c1, c2;
  logic signed [16:0] m_a, m_b;
  logic signed [33:0] m_p;
  logic signed [34:0] m_wide_a;
  logic signed [16:0] m_wide_b;
  logic signed [51:0] m_wide_p;

  always_comb begin
    // idx[3:2] = element i, idx[1:0] = component k; an OP_CRSUB step selects the second term
    ck = cmd.idx[1:0];
    unique case (cmd.idx[3:2])
      2'd0:    begin cp = 2'd1; cq = 2'd2; end
      2'd1:    begin cp = 2'd2; cq = 2'd0; end
      default: begin cp = 2'd0; cq = 2'd1; end
    endcase
    unique case (ck)
      2'd0:    begin c1 = 2'd1; c2 = 2'd2; end
      2'd1:    begin c1 = 2'd2; c2 = 2'd0; end
      default: begin c1 = 2'd0; c2 = 2'd1; end
    endcase
    // first term p[c1]*q[c2]
    m_a = e[cp][c1];
    m_b = e[cq][c2];
    if (cmd.op == tmgr_pkg::OP_CRSUB) begin
      m_a = e[cp][c2];
      m_b = e[cq][c1];
    end
    m_p = m_a * m_b;
    // wide multiply for numerator (cr[i][k]*du[i]) or Jacobian (e0[k]*cr0[k])
    if (cmd.op == tmgr_pkg::OP_JAC) begin
      m_wide_a = cr[0][ck];
      m_wide_b = e[0][ck];
    end else begin
      m_wide_a = cr[cmd.idx[3:2]][ck];
      m_wide_b = du[cmd.idx[3:2]];
    end
    m_wide_p = m_wide_a * m_wide_b;
  end

  assign stat.empty = (jac_sum == 64'sd0);
  assign stat.jac_nonpos = (jac_acc <= 64'sd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) num_sum[k] <= '0;
      jac_sum <= '0;
      sat <= 1'b0;
    end else begin
      if (vtx_we) begin
        vs[vtx_pos][0] <= coord_x;
        vs[vtx_pos][1] <= coord_y;
        vs[vtx_pos][2] <= coord_z;
        vs[vtx_pos][3] <= field_value;
      end
      case (cmd.op)
        tmgr_pkg::OP_EDGE: begin
          for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++)
              e[i][k] <= 17'(vs[i + 1][k]) - 17'(vs[0][k]);
            du[i] <= 17'(vs[i + 1][3]) - 17'(vs[0][3]);
          end
        end
        tmgr_pkg::OP_CROSS: prod_a <= m_p;
        tmgr_pkg::OP_CRSUB: cr[cmd.idx[3:2]][ck] <= 35'(prod_a) - 35'(m_p);
        tmgr_pkg::OP_ACC:
          num_sum[ck] <= num_sum[ck] + 64'(m_wide_p);
        tmgr_pkg::OP_JAC: begin
          if (ck == 2'd0) jac_acc <= 64'(m_wide_p);
          else            jac_acc <= jac_acc + 64'(m_wide_p);
        end
        tmgr_pkg::OP_JACFIN: jac_sum <= jac_sum + jac_acc;
        tmgr_pkg::OP_DIVINIT: begin
          div_neg <= num_sum[cmd.comp][63] ^ jac_sum[63];
          div_a   <= num_sum[cmd.comp][63] ? 64'(-num_sum[cmd.comp]) : num_sum[cmd.comp];
          div_d   <= jac_sum[63] ? 64'(-jac_sum) : jac_sum;
          div_r   <= '0;
          div_q   <= '0;
          div_big <= 1'b0;
        end
        tmgr_pkg::OP_DIVSTEP: begin
          // restoring division of (a << 16) by d, one bit per step, 80 steps
          if ({div_r[63:0], div_a[63]} >= {1'b0, div_d}) begin
            div_r <= {div_r[63:0], div_a[63]} - {1'b0, div_d};
            div_q <= {div_q[46:0], 1'b1};
          end else begin
            div_r <= {div_r[63:0], div_a[63]};
            div_q <= {div_q[46:0], 1'b0};
          end
          if (div_q[47]) div_big <= 1'b1;
          div_a <= {div_a[62:0], 1'b0};
        end
        tmgr_pkg::OP_DIVFIN: begin
          if (div_big || div_q > (div_neg ? 48'h80000000 : 48'h7FFFFFFF)) begin
            grad[cmd.comp] <= div_neg ? 32'sh80000000 : 32'sh7FFFFFFF;
            sat <= 1'b1;
          end else begin
            grad[cmd.comp] <= div_neg ? 32'(-div_q[31:0]) : div_q[31:0];
          end
        end
        tmgr_pkg::OP_CLEAR: begin
          for (int k = 0; k < 3; k++) num_sum[k] <= '0;
          jac_sum <= '0;
          sat <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: src/tmgr_ctrl.sv
// Controller: sequences element computation, division and result handshake
module tmgr_ctrl (
  input  logic               clk,
  input  logic               rst,
  tmgr_vertex_if.sink        vin,
  tmgr_grad_if.source        gout,
  output logic               vtx_we,
  output logic [1:0]         vtx_pos,
  output tmgr_pkg::dp_cmd_t  cmd,
  input  tmgr_pkg::dp_stat_t stat,
  input  logic signed [31:0] grad [3],
  input  logic               sat
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_EDGE  = 9'b000000010,
    S_CROSS = 9'b000000100,
    S_CRSUB = 9'b000001000,
    S_ACC   = 9'b000010000,
    S_JAC   = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_DSTEP = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;
  logic [1:0] pos;
  logic [tmgr_pkg::CountW-1:0] count;
  logic bad_seen;
  logic last_pend;
  logic [3:0] step;
  logic [1:0] comp;
  logic [6:0] dcnt;
  logic out_valid;
  logic signed [31:0] out_g [3];
  logic [1:0] out_status;
  logic accept;
  logic do_elem;
  logic out_free;

  assign vin.ready = (state == S_IDLE) && !rst;
  assign accept = vin.valid && vin.ready;
  assign vtx_we = accept;
  assign vtx_pos = pos;
  assign do_elem = (pos == 2'd3) && (count < 7'(tmgr_pkg::MaxElements));
  // result register can take a new result
  assign out_free = !out_valid || gout.ready;

  assign gout.valid  = out_valid;
  assign gout.grad_x = out_g[0];
  assign gout.grad_y = out_g[1];
  assign gout.grad_z = out_g[2];
  assign gout.status = out_status;

  // Command decode
  always_comb begin
    cmd.op = tmgr_pkg::OP_NONE;
    cmd.idx = step;
    cmd.comp = comp;
    unique case (state)
      S_EDGE:  cmd.op = tmgr_pkg::OP_EDGE;
      S_CROSS: cmd.op = tmgr_pkg::OP_CROSS;
      S_CRSUB: cmd.op = tmgr_pkg::OP_CRSUB;
      S_ACC:   cmd.op = tmgr_pkg::OP_ACC;
      S_JAC:   cmd.op = (step[3:2] == 2'd3) ? tmgr_pkg::OP_JACFIN : tmgr_pkg::OP_JAC;
      S_DIV:   cmd.op = tmgr_pkg::OP_DIVINIT;
      S_DSTEP: cmd.op = (dcnt == 7'd80) ? tmgr_pkg::OP_DIVFIN : tmgr_pkg::OP_DIVSTEP;
      S_OUT:   cmd.op = out_free ? tmgr_pkg::OP_CLEAR : tmgr_pkg::OP_NONE;
      default: cmd.op = tmgr_pkg::OP_NONE;
    endcase
    if (state == S_JAC) cmd.idx = {2'd0, step[1:0]};
  end

  // Step counter walks i in idx[3:2] (0..2) and k in idx[1:0] (0..2)
  function automatic logic [3:0] next_step(input logic [3:0] s);
    logic [3:0] r;
    if (s[1:0] == 2'd2) r = {s[3:2] + 2'd1, 2'd0};
    else r = {s[3:2], s[1:0] + 2'd1};
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pos <= '0;
      count <= '0;
      bad_seen <= 1'b0;
      last_pend <= 1'b0;
      step <= '0;
      comp <= '0;
      dcnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) out_valid <= 1'b1;
      else if (gout.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (accept) begin
          pos <= pos + 2'd1;
          last_pend <= vin.last_in_set;
          if (pos == 2'd3 && !do_elem) count <= 7'(tmgr_pkg::MaxElements + 1);
          if (do_elem) begin
            state <= S_EDGE;
          end else if (vin.last_in_set) begin
            comp <= '0;
            state <= S_DIV;
          end
        end
        S_EDGE: begin step <= '0; state <= S_CROSS; end
        S_CROSS: state <= S_CRSUB;
        S_CRSUB: begin
          if (step == 4'b1010) begin step <= '0; state <= S_ACC; end
          else begin step <= next_step(step); state <= S_CROSS; end
        end
        S_ACC: begin
          if (step == 4'b1010) begin step <= '0; state <= S_JAC; end
          else step <= next_step(step);
        end
        S_JAC: begin
          if (step[3:2] == 2'd3) begin
            count <= count + 7'd1;
            step <= '0;
            if (last_pend) begin comp <= '0; state <= S_DIV; end
            else state <= S_IDLE;
          end else if (step[1:0] == 2'd2) step <= 4'b1100;
          else step <= step + 4'd1;
        end
        S_DIV: begin dcnt <= '0; state <= S_DSTEP; end
        S_DSTEP: begin
          if (dcnt == 7'd80) begin
            if (comp == 2'd2) state <= S_OUT;
            else begin comp <= comp + 2'd1; state <= S_DIV; end
          end else dcnt <= dcnt + 7'd1;
        end
        // wait here while the previous result is still unread
        S_OUT: if (out_free) begin
          if (count == '0 || stat.empty) begin
            out_g[0] <= '0; out_g[1] <= '0; out_g[2] <= '0;
            out_status <= tmgr_pkg::STATUS_EMPTY;
          end else begin
            out_g <= grad;
            if (bad_seen) out_status <= tmgr_pkg::STATUS_BAD_JAC;
            else if (sat || count > 7'(tmgr_pkg::MaxElements))
              out_status <= tmgr_pkg::STATUS_SAT;
            else out_status <= tmgr_pkg::STATUS_OK;
          end
          pos <= '0;
          count <= '0;
          bad_seen <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_JAC && step[3:2] == 2'd3 && stat.jac_nonpos) bad_seen <= 1'b1;
    end
  end

endmodule

// File: src/tet_mesh_gradient_recovery.sv
// Top level: volume-weighted tetrahedral gradient recovery
// Vertices are taken one per transfer, four per element. The fourth vertex of an
// element starts element work on one shared multiplier pair (edge vectors, cross
// products, numerator products, then Jacobian) before the next vertex is taken. The
// last vertex of a set then adds three restoring divisions, one per component, and
// a load of the result register. A result that waits for its transfer does not hold off
// the next set until that set's own result is ready.
module tet_mesh_gradient_recovery (
  input  logic         clk,
  input  logic         rst,
  tmgr_vertex_if.sink  vin,
  tmgr_grad_if.source  gout
);

  logic               vtx_we;
  logic [1:0]         vtx_pos;
  tmgr_pkg::dp_cmd_t  cmd;
  tmgr_pkg::dp_stat_t stat;
  logic signed [31:0] grad [3];
  logic               sat;

  tmgr_ctrl u_ctrl (
    .clk, .rst, .vin, .gout, .vtx_we, .vtx_pos, .cmd, .stat, .grad, .sat
  );

  tmgr_datapath u_dp (
    .clk, .rst, .vtx_we, .vtx_pos,
    .coord_x(vin.coord_x), .coord_y(vin.coord_y), .coord_z(vin.coord_z),
    .field_value(vin.field_value),
    .cmd, .stat, .grad, .sat
  );

  // Result payload holds while it waits
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    gout.valid && !gout.ready |=>
      $stable({gout.grad_x, gout.grad_y, gout.grad_z, gout.status}))
    else $error("result changed while waiting");

  // A result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    gout.valid && !gout.ready |=> gout.valid) else $error("result dropped");

endmodule

// File: tb/sv/tmgr_checker.sv
// Checker: predicts gradient results from observed vertex transfers and compares them
module tmgr_checker (
  input  logic    clk,
  input  logic    rst,
  tmgr_vertex_if  vin,
  tmgr_grad_if    gout,
  output int      fail_count,
  output int      pending
);

  typedef struct {
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic signed [31:0] gz;
    tmgr_pkg::status_t  st;
  } grad_result_t;

  grad_result_t grad_queue[$];

  // predicted block state
  longint vx[4], vy[4], vz[4], vf[4];
  int     corner;
  longint num_sum[3];
  longint jac_sum;
  int     elem_count;
  bit     bad_jac;

  assign pending = grad_queue.size();

  // signed (num << 16) / den toward zero, bit 32 flags saturation
  function automatic logic [32:0] q16_quot(longint num, longint den);
    logic [127:0] a, d, q, lim;
    bit neg;
    bit sat;
    logic [31:0] r;
    neg = (num < 0) != (den < 0);
    a = 128'(num < 0 ? -num : num);
    d = 128'(den < 0 ? -den : den);
    q = (a << 16) / d;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    sat = 0;
    if (q > lim) begin
      q = lim;
      sat = 1;
    end
    r = neg ? -q[31:0] : q[31:0];
    return {sat, r};
  endfunction

  // accumulate one complete tetrahedron
  task automatic add_tet();
    longint e[3][3];
    longint cr[3][3];
    longint jac;
    if (elem_count >= tmgr_pkg::MaxElements) begin
      elem_count = tmgr_pkg::MaxElements + 1;
      return;
    end
    for (int i = 0; i < 3; i++) begin
      e[i][0] = vx[i+1] - vx[0];
      e[i][1] = vy[i+1] - vy[0];
      e[i][2] = vz[i+1] - vz[0];
    end
    for (int i = 0; i < 3; i++) begin
      int p, q;
      p = (i + 1) % 3;
      q = (i + 2) % 3;
      cr[i][0] = e[p][1] * e[q][2] - e[p][2] * e[q][1];
      cr[i][1] = e[p][2] * e[q][0] - e[p][0] * e[q][2];
      cr[i][2] = e[p][0] * e[q][1] - e[p][1] * e[q][0];
    end
    jac = e[0][0] * cr[0][0] + e[0][1] * cr[0][1] + e[0][2] * cr[0][2];
    for (int k = 0; k < 3; k++)
      for (int i = 0; i < 3; i++)
        num_sum[k] += cr[i][k] * (vf[i+1] - vf[0]);
    jac_sum += jac;
    if (jac <= 0) bad_jac = 1;
    elem_count++;
  endtask

  // one vertex transfer, pushes a result on the last vertex of a set
  task automatic take_vertex();
    grad_result_t res;
    logic [32:0] qx, qy, qz;
    vx[corner] = vin.coord_x;
    vy[corner] = vin.coord_y;
    vz[corner] = vin.coord_z;
    vf[corner] = vin.field_value;
    if (corner == 3) begin
      add_tet();
      corner = 0;
    end else begin
      corner++;
    end
    if (!vin.last_in_set) return;
    res.gx = 0;
    res.gy = 0;
    res.gz = 0;
    if (elem_count == 0 || jac_sum == 0) begin
      res.st = tmgr_pkg::STATUS_EMPTY;
    end else begin
      qx = q16_quot(num_sum[0], jac_sum);
      qy = q16_quot(num_sum[1], jac_sum);
      qz = q16_quot(num_sum[2], jac_sum);
      res.gx = qx[31:0];
      res.gy = qy[31:0];
      res.gz = qz[31:0];
      if (bad_jac) res.st = tmgr_pkg::STATUS_BAD_JAC;
      else if (qx[32] || qy[32] || qz[32] || elem_count > tmgr_pkg::MaxElements)
        res.st = tmgr_pkg::STATUS_SAT;
      else res.st = tmgr_pkg::STATUS_OK;
    end
    grad_queue.push_back(res);
    corner = 0;
    num_sum = '{0, 0, 0};
    jac_sum = 0;
    elem_count = 0;
    bad_jac = 0;
  endtask

  // watch both channels
  always @(posedge clk) begin
    grad_result_t want;
    if (rst) begin
      corner = 0;
      num_sum = '{0, 0, 0};
      jac_sum = 0;
      elem_count = 0;
      bad_jac = 0;
      fail_count = 0;
      grad_queue.delete();
    end else begin
      if (vin.valid && vin.ready) take_vertex();
      if (gout.valid && gout.ready) begin
        if (grad_queue.size() == 0) begin
          $error("unexpected gradient transfer");
          fail_count++;
        end else begin
          want = grad_queue.pop_front();
          if (gout.grad_x !== want.gx) begin
            $error("grad_x expected %0d actual %0d", want.gx, gout.grad_x);
            fail_count++;
          end
          if (gout.grad_y !== want.gy) begin
            $error("grad_y expected %0d actual %0d", want.gy, gout.grad_y);
            fail_count++;
          end
          if (gout.grad_z !== want.gz) begin
            $error("grad_z expected %0d actual %0d", want.gz, gout.grad_z);
            fail_count++;
          end
          if (gout.status !== want.st) begin
            $error("status expected %0d actual %0d", want.st, gout.status);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top: vertex stimulus, result back-pressure and final verdict
module tb_top;

  localparam int TotalItems = 850;
  localparam int CycleLimit = 2000000;
  localparam int HoldCycles = 900;

  logic clk = 0;
  logic rst = 1;

  tmgr_vertex_if vin (clk);
  tmgr_grad_if   gout (clk);

  int fail_count;
  int pending;

  tet_mesh_gradient_recovery dut (.clk(clk), .rst(rst), .vin(vin), .gout(gout));
  tmgr_checker chk (.clk(clk), .rst(rst), .vin(vin), .gout(gout),
                    .fail_count(fail_count), .pending(pending));

  always #5 clk = ~clk;

  // vertex word: {last, x, y, z, field}
  logic [64:0] vert_list[$];
  int  ptr;
  int  in_gap;
  int  out_gap;
  int  hold_left;
  bit  held;
  int  cycles = 0;
  bit  tail;

  task automatic put(int x, int y, int z, int f, bit last);
    vert_list.push_back({last, 16'(x), 16'(y), 16'(z), 16'(f)});
  endtask

  // triple product, whose sign gives the orientation
  function automatic longint tet_vol(int ax, int ay, int az, int bx, int by, int bz,
                                     int cx, int cy, int cz, int dx, int dy, int dz);
    longint e0x, e0y, e0z, e1x, e1y, e1z, e2x, e2y, e2z;
    e0x = bx - ax; e0y = by - ay; e0z = bz - az;
    e1x = cx - ax; e1y = cy - ay; e1z = cz - az;
    e2x = dx - ax; e2y = dy - ay; e2z = dz - az;
    return e0x * (e1y * e2z - e1z * e2y) + e0y * (e1z * e2x - e1x * e2z)
         + e0z * (e1x * e2y - e1y * e2x);
  endfunction

  // one random tetrahedron, mostly positively oriented
  task automatic rand_tet(bit last, int span, bit wide_field);
    int p[4][4];
    int t;
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 3; k++)
        p[i][k] = (i == 0) ? $signed(16'($urandom))
                           : p[0][k] + $signed($urandom_range(0, 2 * span)) - span;
      p[i][3] = wide_field ? $signed(16'($urandom)) : $signed($urandom_range(0, 2048)) - 1024;
    end
    for (int i = 1; i < 4; i++)
      for (int k = 0; k < 3; k++)
        p[i][k] = $signed(16'(p[i][k]));
    if ($urandom_range(0, 9) < 8 &&
        tet_vol(p[0][0], p[0][1], p[0][2], p[1][0], p[1][1], p[1][2],
                p[2][0], p[2][1], p[2][2], p[3][0], p[3][1], p[3][2]) < 0)
      for (int k = 0; k < 4; k++) begin
        t = p[2][k]; p[2][k] = p[3][k]; p[3][k] = t;
      end
    for (int i = 0; i < 4; i++)
      put(p[i][0], p[i][1], p[i][2], p[i][3], last && i == 3);
  endtask

  // directed sets, then random sets
  initial begin
    int nel, span, n;
    put(100, 200, 300, 5, 1);                 // empty set
    put(0, 0, 0, 0, 0);                       // corner tetrahedron with edges of 256
    put(256, 0, 0, 512, 0);
    put(0, 256, 0, -256, 0);
    put(0, 0, 256, 1024, 1);
    put(0, 0, 0, 0, 0);                       // inverted orientation
    put(256, 0, 0, 512, 0);
    put(0, 0, 256, 1024, 0);
    put(0, 256, 0, -256, 1);
    for (int i = 0; i < 4; i++)               // flat element, zero volume
      put(77, -77, 300, i * 100, i == 3);
    put(0, 0, 0, -32768, 0);                  // tiny volume, saturates
    put(1, 0, 0, 32767, 0);
    put(0, 1, 0, 0, 0);
    put(0, 0, 1, 0, 1);
    put(-32768, -32768, -32768, -32768, 0);   // field extremes
    put(32767, -32768, -32768, 32767, 0);
    put(-32768, 32767, -32768, 0, 0);
    put(-32768, -32768, 32767, -1, 1);
    put(0, 0, 0, 0, 0);                       // partial element dropped at end
    put(512, 0, 0, 100, 0);
    put(0, 512, 0, 200, 0);
    put(0, 0, 512, 300, 0);
    put(5, 5, 5, 5, 0);
    put(6, 6, 6, 6, 1);
    n = 0;
    while (vert_list.size() < TotalItems) begin
      n++;
      if (n == 20) begin
        // more elements than the block keeps
        for (int e = 0; e < 66; e++) begin
          put(0, 0, 0, 0, 0);
          put(256, 0, 0, e, 0);
          put(0, 256, 0, 3, 0);
          put(0, 0, 256, -9, e == 65);
        end
      end else if ($urandom_range(0, 9) == 0) begin
        // noise: arbitrary vertices, set may end mid-element
        nel = $urandom_range(1, 9);
        for (int i = 0; i < nel; i++)
          put($signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)),
              $signed(16'($urandom)), i == nel - 1);
      end else begin
        nel = $urandom_range(1, 6);
        span = ($urandom_range(0, 3) == 0) ? 16000 : $urandom_range(1, 600);
        for (int e = 0; e < nel; e++)
          rand_tet(e == nel - 1, span, $urandom_range(0, 4) == 0);
      end
    end
  end

  // vertex source
  always @(posedge clk) begin
    if (rst) begin
      vin.valid <= 0;
      vin.coord_x <= 0;
      vin.coord_y <= 0;
      vin.coord_z <= 0;
      vin.field_value <= 0;
      vin.last_in_set <= 0;
      ptr = 0;
      in_gap = 0;
    end else begin
      if (vin.valid && vin.ready) begin
        ptr++;
        if (!tail && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 14);
      end
      if (in_gap > 0) begin
        in_gap--;
        vin.valid <= 0;
      end else if (ptr < vert_list.size()) begin
        vin.valid <= 1;
        {vin.last_in_set, vin.coord_x, vin.coord_y, vin.coord_z, vin.field_value}
          <= vert_list[ptr];
      end else begin
        vin.valid <= 0;
      end
    end
  end

  // result sink with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      gout.ready <= 0;
      out_gap = 0;
      hold_left = 0;
      held = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      gout.ready <= 0;
    end else if (!held && ptr >= 200) begin
      held = 1;
      hold_left = HoldCycles;
      gout.ready <= 0;
    end else if (out_gap > 0) begin
      out_gap--;
      gout.ready <= 0;
    end else if (!tail && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(1, 13);
      gout.ready <= 0;
    end else begin
      gout.ready <= 1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    tail <= vert_list.size() > 0 && ptr > vert_list.size() * 85 / 100;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    wait (vert_list.size() > 0 && ptr == vert_list.size());
    wait (pending == 0);
    repeat (400) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/tmgr_pkg.sv
src/tmgr_if.sv
src/tmgr_datapath.sv
src/tmgr_ctrl.sv
src/tet_mesh_gradient_recovery.sv
tb/sv/tmgr_checker.sv
tb/sv/tb_top.sv
